[rtl/burst_class_priority_deque_top_assert.svh]
// assertion macros shared by the deque checker
`ifndef BURST_CLASS_PRIORITY_DEQUE_TOP_ASSERT_SVH
`define BURST_CLASS_PRIORITY_DEQUE_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define BCPD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bcpd assertion failed");

// next-cycle implication, sampled on clk_i, off during reset
`define BCPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bcpd assertion failed");

`endif

[rtl/bcpd_pkg.sv]
// ----------------------------------------------------------------------------
// bcpd_pkg
// Shared types and constants of the burst class priority deque.
// ----------------------------------------------------------------------------
package bcpd_pkg;

  localparam int unsigned CNT_W    = 32;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned REG_IDX_W = APB_AW - 2;

  localparam logic [REG_IDX_W-1:0] REG_DEFAULT_CLASS = '0;

  typedef enum logic [1:0] {
    OP_SCHEDULE = 2'd0,
    OP_TAKE     = 2'd1,
    OP_STEAL    = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

endpackage

[rtl/bcpd_apb.sv]
// ----------------------------------------------------------------------------
// bcpd_apb
// Configuration register file behind a simple APB-style slave port.
// ----------------------------------------------------------------------------
module bcpd_apb
  import bcpd_pkg::*;
#(
  parameter int unsigned NUM_CLASSES = 4,
  localparam int unsigned CLS_W = $clog2(NUM_CLASSES + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [CLS_W-1:0]  default_class_o
);

  logic [CLS_W-1:0]     default_class_q, default_class_d;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[APB_AW-1:2];
  assign wr_en   = psel & penable & pwrite & (reg_idx == REG_DEFAULT_CLASS);
  assign pready  = 1'b1;

  always_comb begin
    default_class_d = default_class_q;
    if (wr_en) begin
      default_class_d = pwdata[CLS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_class_q <= CLS_W'(NUM_CLASSES);
    end else begin
      default_class_q <= default_class_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_DEFAULT_CLASS) begin
      prdata = APB_DW'(default_class_q);
    end
  end

  assign default_class_o = default_class_q;

endmodule

[rtl/bcpd_ctrl.sv]
// ----------------------------------------------------------------------------
// bcpd_ctrl
// Sequencer: captures one transaction, runs its execute cycle once the
// result register is free, and tracks the result valid flag.
// ----------------------------------------------------------------------------
module bcpd_ctrl
  import bcpd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // result register empty or emptied this cycle
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_EXEC: begin
        cmd_o.exec = out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.exec) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[rtl/bcpd_dpath.sv]
// ----------------------------------------------------------------------------
// bcpd_dpath
// Per-class ring pointers and fill counts, class selection, task store and
// result registers.
// ----------------------------------------------------------------------------
module bcpd_dpath
  import bcpd_pkg::*;
#(
  parameter int unsigned NUM_CLASSES = 4,
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_WIDTH    = 16,
  localparam int unsigned CLS_W  = $clog2(NUM_CLASSES + 1),
  localparam int unsigned TOT_W  = $clog2(NUM_CLASSES * QUEUE_DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctrl_cmd_t           cmd_i,
  input  logic [CLS_W-1:0]    default_class_i,
  input  logic [1:0]          op_i,
  input  logic [ID_WIDTH-1:0] task_id_i,
  input  logic [CLS_W-1:0]    burst_class_i,
  output logic [1:0]          status_o,
  output logic [ID_WIDTH-1:0] task_out_o,
  output logic [CLS_W-1:0]    class_out_o,
  output logic [TOT_W-1:0]    queued_total_o,
  output logic [CNT_W-1:0]    scheduled_count_o,
  output logic [CNT_W-1:0]    taken_count_o,
  output logic [CNT_W-1:0]    stolen_count_o
);

  localparam int unsigned CIDX_W    = $clog2(NUM_CLASSES);
  localparam int unsigned PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int unsigned FILL_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ADDR_W    = CIDX_W + PTR_W;
  localparam int unsigned MEM_DEPTH = 1 << ADDR_W;

  // captured transaction
  logic [1:0]          op_q;
  logic [ID_WIDTH-1:0] id_q;
  logic [CLS_W-1:0]    bc_q;

  // per-class state
  logic [PTR_W-1:0]  head_q [NUM_CLASSES];
  logic [PTR_W-1:0]  tail_q [NUM_CLASSES];
  logic [FILL_W-1:0] fill_q [NUM_CLASSES];
  logic [TOT_W-1:0]  total_q;
  logic [CNT_W-1:0]  sched_cnt_q, take_cnt_q, steal_cnt_q;

  logic [ID_WIDTH-1:0] task_store_q [MEM_DEPTH];
  logic [ID_WIDTH-1:0] rdata_q;

  logic [1:0]       status_q, status_d;
  logic [CLS_W-1:0] cls_out_q, cls_out_d;
  logic             popped_q;

  op_e                op;
  logic               bc_ok, def_ok, any_queued, full;
  logic [CLS_W-1:0]   sched_cls;
  logic [CIDX_W-1:0]  sched_idx, take_idx, steal_idx, sel_idx;
  logic [FILL_W-1:0]  sel_fill;
  logic [PTR_W-1:0]   head_sel, tail_sel, head_next, tail_next, tail_prev, slot;
  logic [ADDR_W-1:0]  mem_addr;
  logic               do_push, do_take, do_steal, do_pop;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= op_i;
      id_q <= task_id_i;
      bc_q <= burst_class_i;
    end
  end

  assign op = op_e'(op_q);

  // undefined or out-of-range classes fall back to the default, then longest
  assign bc_ok  = (bc_q != '0) && (bc_q <= CLS_W'(NUM_CLASSES));
  assign def_ok = (default_class_i != '0) && (default_class_i <= CLS_W'(NUM_CLASSES));
  assign sched_cls = bc_ok ? bc_q : (def_ok ? default_class_i : CLS_W'(NUM_CLASSES));
  assign sched_idx = CIDX_W'(sched_cls - CLS_W'(1));

  // priority search over the class fill counts
  always_comb begin
    take_idx   = '0;
    steal_idx  = '0;
    any_queued = 1'b0;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (fill_q[c] != '0) begin
        take_idx = CIDX_W'(c);
      end
    end
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (fill_q[c] != '0) begin
        steal_idx  = CIDX_W'(c);
        any_queued = 1'b1;
      end
    end
  end

  always_comb begin
    unique case (op)
      OP_TAKE:  sel_idx = take_idx;
      OP_STEAL: sel_idx = steal_idx;
      default:  sel_idx = sched_idx;
    endcase
  end

  assign sel_fill = fill_q[sel_idx];
  assign head_sel = head_q[sel_idx];
  assign tail_sel = tail_q[sel_idx];
  assign full     = (sel_fill == FILL_W'(QUEUE_DEPTH));

  assign head_next = (head_sel == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_sel + PTR_W'(1);
  assign tail_next = (tail_sel == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_sel + PTR_W'(1);
  assign tail_prev = (tail_sel == '0) ? PTR_W'(QUEUE_DEPTH - 1) : tail_sel - PTR_W'(1);

  always_comb begin
    do_push   = 1'b0;
    do_take   = 1'b0;
    do_steal  = 1'b0;
    status_d  = ST_OK;
    cls_out_d = '0;
    unique case (op)
      OP_SCHEDULE: begin
        do_push   = cmd_i.exec & !full;
        status_d  = full ? ST_FULL : ST_OK;
        cls_out_d = sched_cls;
      end
      OP_TAKE: begin
        do_take   = cmd_i.exec & any_queued;
        status_d  = any_queued ? ST_OK : ST_EMPTY;
        cls_out_d = any_queued ? CLS_W'(sel_idx) + CLS_W'(1) : '0;
      end
      OP_STEAL: begin
        do_steal  = cmd_i.exec & any_queued;
        status_d  = any_queued ? ST_OK : ST_EMPTY;
        cls_out_d = any_queued ? CLS_W'(sel_idx) + CLS_W'(1) : '0;
      end
      OP_NONE: begin
        status_d  = ST_OK;
      end
      default: begin
        status_d  = ST_OK;
      end
    endcase
  end

  assign do_pop = do_take | do_steal;

  always_comb begin
    priority if (do_steal) begin
      slot = tail_prev;
    end else if (do_take) begin
      slot = head_sel;
    end else begin
      slot = tail_sel;
    end
  end

  assign mem_addr = {sel_idx, slot};

  // task store: at most one write or one registered read per transaction
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      task_store_q[mem_addr] <= id_q;
    end
    if (do_pop) begin
      rdata_q <= task_store_q[mem_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head_q[c] <= '0;
        tail_q[c] <= '0;
        fill_q[c] <= '0;
      end
      total_q     <= '0;
      sched_cnt_q <= '0;
      take_cnt_q  <= '0;
      steal_cnt_q <= '0;
    end else begin
      if (do_push) begin
        tail_q[sel_idx] <= tail_next;
        fill_q[sel_idx] <= sel_fill + FILL_W'(1);
        total_q         <= total_q + TOT_W'(1);
        sched_cnt_q     <= sched_cnt_q + CNT_W'(1);
      end
      if (do_take) begin
        head_q[sel_idx] <= head_next;
        take_cnt_q      <= take_cnt_q + CNT_W'(1);
      end
      if (do_steal) begin
        tail_q[sel_idx] <= tail_prev;
        steal_cnt_q     <= steal_cnt_q + CNT_W'(1);
      end
      if (do_pop) begin
        fill_q[sel_idx] <= sel_fill - FILL_W'(1);
        total_q         <= total_q - TOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q  <= status_d;
      cls_out_q <= cls_out_d;
      popped_q  <= do_pop;
    end
  end

  assign status_o          = status_q;
  assign class_out_o       = cls_out_q;
  assign task_out_o        = popped_q ? rdata_q : '0;
  assign queued_total_o    = total_q;
  assign scheduled_count_o = sched_cnt_q;
  assign taken_count_o     = take_cnt_q;
  assign stolen_count_o    = steal_cnt_q;

endmodule

[rtl/burst_class_priority_deque_top.sv]
// ----------------------------------------------------------------------------
// burst_class_priority_deque_top
// Multilevel priority deque of task ids, one ring per burst class.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (op_i, task_id_i, burst_class_i) and result channel
//   (status_o, task_out_o, class_out_o, queued_total_o and the three
//   counters) are valid/ready. Every input transaction gives one result.
//   Schedule appends to its class, take pops the head of the shortest
//   nonempty class, steal pops the tail of the longest nonempty class.
//   The default class register sits at byte address 0 of the APB port.
// Timing:
//   A transaction is captured in S_IDLE and executed in S_EXEC, where the
//   per-class pointer lookup and the single task store access happen, once
//   the result register is free; the result valid flag is set at execute.
//   No new transaction is accepted until the last one has executed.
// Reset:
//   All classes empty, counters zero, default class the longest. No
//   clearing pass: fill counts guard the task store.
// Stall:
//   While a result waits, the next transaction is still captured; its
//   execute cycle waits until the result register is taken.
// ----------------------------------------------------------------------------
module burst_class_priority_deque_top
  import bcpd_pkg::*;
#(
  parameter int unsigned NUM_CLASSES = 4,
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_WIDTH    = 16,
  localparam int unsigned CLS_W = $clog2(NUM_CLASSES + 1),
  localparam int unsigned TOT_W = $clog2(NUM_CLASSES * QUEUE_DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          op_i,
  input  logic [ID_WIDTH-1:0] task_id_i,
  input  logic [CLS_W-1:0]    burst_class_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          status_o,
  output logic [ID_WIDTH-1:0] task_out_o,
  output logic [CLS_W-1:0]    class_out_o,
  output logic [TOT_W-1:0]    queued_total_o,
  output logic [CNT_W-1:0]    scheduled_count_o,
  output logic [CNT_W-1:0]    taken_count_o,
  output logic [CNT_W-1:0]    stolen_count_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready
);

  ctrl_cmd_t        cmd;
  logic [CLS_W-1:0] default_class;

  bcpd_apb #(
    .NUM_CLASSES (NUM_CLASSES)
  ) u_apb (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .default_class_o (default_class)
  );

  bcpd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  bcpd_dpath #(
    .NUM_CLASSES (NUM_CLASSES),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_WIDTH    (ID_WIDTH)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .default_class_i   (default_class),
    .op_i              (op_i),
    .task_id_i         (task_id_i),
    .burst_class_i     (burst_class_i),
    .status_o          (status_o),
    .task_out_o        (task_out_o),
    .class_out_o       (class_out_o),
    .queued_total_o    (queued_total_o),
    .scheduled_count_o (scheduled_count_o),
    .taken_count_o     (taken_count_o),
    .stolen_count_o    (stolen_count_o)
  );

endmodule

[rtl/bcpd_checker.sv]
// ----------------------------------------------------------------------------
// bcpd_checker
// Port-level checks on the deque, bound to the top level.
// ----------------------------------------------------------------------------
`include "burst_class_priority_deque_top_assert.svh"

module bcpd_checker
  import bcpd_pkg::*;
#(
  parameter int unsigned NUM_CLASSES = 4,
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_WIDTH    = 16,
  localparam int unsigned CLS_W = $clog2(NUM_CLASSES + 1),
  localparam int unsigned TOT_W = $clog2(NUM_CLASSES * QUEUE_DEPTH + 1)
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [1:0]          status_o,
  input logic [ID_WIDTH-1:0] task_out_o,
  input logic [CLS_W-1:0]    class_out_o,
  input logic [TOT_W-1:0]    queued_total_o
);

  // a pending result stays offered
  `BCPD_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)

  // a captured transaction blocks the input for its execute cycle
  `BCPD_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)

  // no task id leaks out of a failed transaction
  `BCPD_ASSERT_NOW(a_no_task_on_error, out_valid_o && (status_o != ST_OK),
                   task_out_o == '0)

  // a rejected schedule names its class, and the deque holds tasks
  `BCPD_ASSERT_NOW(a_full_has_class, out_valid_o && (status_o == ST_FULL),
                   (class_out_o != '0) && (queued_total_o != '0))

endmodule

bind burst_class_priority_deque_top bcpd_checker #(
  .NUM_CLASSES (NUM_CLASSES),
  .QUEUE_DEPTH (QUEUE_DEPTH),
  .ID_WIDTH    (ID_WIDTH)
) u_bcpd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .status_o       (status_o),
  .task_out_o     (task_out_o),
  .class_out_o    (class_out_o),
  .queued_total_o (queued_total_o)
);

[tb/burst_class_priority_deque_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// burst_class_priority_deque_top_tb
// Drives schedule, take and steal transactions into the deque and checks each
// result field by field against a directed table or a shadow of the class rings,
// under changing default class settings and sender and receiver stalls.
// ----------------------------------------------------------------------------
module burst_class_priority_deque_top_tb
  import bcpd_pkg::*;
();

  localparam int NCLS  = 4;
  localparam int DEPTH = 16;

  typedef struct packed {
    status_e     status;
    logic [15:0] task_id;
    logic [2:0]  cls;
    logic [6:0]  total;
    logic [31:0] n_sched;
    logic [31:0] n_taken;
    logic [31:0] n_stolen;
  } deque_result_t;

  typedef struct {
    op_e           op;
    logic [15:0]   id;
    logic [2:0]    cls;
    int            reps;
    bit            typed;
    deque_result_t want;
  } dir_row_t;

  localparam deque_result_t NO_RESULT = '{ST_OK, 16'h0, 3'd0, 7'd0, 32'd0, 32'd0, 32'd0};
  localparam deque_result_t EMPTY_RESULT =
    '{ST_EMPTY, 16'h0, 3'd0, 7'd0, 32'd0, 32'd0, 32'd0};
  localparam int DIR_ROWS = 13;

  // directed rows: empty pops, unused op, field extremes, default class, full class
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{OP_TAKE,     16'h0000, 3'd0, 1,  1'b1, EMPTY_RESULT},
    '{OP_STEAL,    16'h0000, 3'd0, 1,  1'b1, EMPTY_RESULT},
    '{OP_NONE,     16'hFFFF, 3'd7, 1,  1'b1, NO_RESULT},
    '{OP_SCHEDULE, 16'hFFFF, 3'd1, 1,  1'b1,
      '{ST_OK, 16'h0000, 3'd1, 7'd1, 32'd1, 32'd0, 32'd0}},
    '{OP_SCHEDULE, 16'h0000, 3'd0, 1,  1'b1,
      '{ST_OK, 16'h0000, 3'd4, 7'd2, 32'd2, 32'd0, 32'd0}},
    '{OP_SCHEDULE, 16'hA5A5, 3'd7, 1,  1'b1,
      '{ST_OK, 16'h0000, 3'd4, 7'd3, 32'd3, 32'd0, 32'd0}},
    '{OP_TAKE,     16'h0000, 3'd0, 1,  1'b1,
      '{ST_OK, 16'hFFFF, 3'd1, 7'd2, 32'd3, 32'd1, 32'd0}},
    '{OP_STEAL,    16'h0000, 3'd0, 1,  1'b1,
      '{ST_OK, 16'hA5A5, 3'd4, 7'd1, 32'd3, 32'd1, 32'd1}},
    '{OP_SCHEDULE, 16'h5A50, 3'd3, 16, 1'b0, NO_RESULT},
    '{OP_SCHEDULE, 16'h1111, 3'd3, 1,  1'b1,
      '{ST_FULL, 16'h0000, 3'd3, 7'd17, 32'd19, 32'd1, 32'd1}},
    '{OP_SCHEDULE, 16'h8000, 3'd2, 1,  1'b0, NO_RESULT},
    '{OP_STEAL,    16'h0000, 3'd0, 1,  1'b0, NO_RESULT},
    '{OP_TAKE,     16'h0000, 3'd0, 1,  1'b0, NO_RESULT}
  };

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [1:0]        op_i = OP_NONE;
  logic [15:0]       task_id_i = '0;
  logic [2:0]        burst_class_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [1:0]        status_o;
  logic [15:0]       task_out_o;
  logic [2:0]        class_out_o;
  logic [6:0]        queued_total_o;
  logic [CNT_W-1:0]  scheduled_count_o;
  logic [CNT_W-1:0]  taken_count_o;
  logic [CNT_W-1:0]  stolen_count_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  burst_class_priority_deque_top uut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .op_i, .task_id_i, .burst_class_i,
    .out_valid_o, .out_ready_i, .status_o, .task_out_o, .class_out_o,
    .queued_total_o, .scheduled_count_o, .taken_count_o, .stolen_count_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the per-class rings and counters
  logic [15:0] id_store [NCLS][DEPTH];
  int          head_ix [NCLS] = '{default: 0};
  int          tail_ix [NCLS] = '{default: 0};
  int          fill_cnt [NCLS] = '{default: 0};
  logic [31:0] sched_total = '0;
  logic [31:0] taken_total = '0;
  logic [31:0] stolen_total = '0;
  logic [2:0]  dflt_cls = 3'd4;

  deque_result_t awaited_results [$];
  deque_result_t want_r;
  int mismatches = 0;
  int cfg_errors = 0;
  int n_checked = 0;
  int n_full = 0;
  int n_empty = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;

  function automatic deque_result_t next_deque_result(op_e op, logic [15:0] id,
                                                      logic [2:0] bc);
    deque_result_t r;
    logic [2:0] cls;
    int q;
    bit found;
    r = NO_RESULT;
    found = 1'b0;
    case (op)
      OP_SCHEDULE: begin
        cls = bc;
        if (cls == 0 || cls > NCLS) begin
          cls = dflt_cls;
          if (cls == 0 || cls > NCLS) cls = 3'(NCLS);
        end
        q = cls - 1;
        r.cls = cls;
        if (fill_cnt[q] >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          id_store[q][tail_ix[q]] = id;
          tail_ix[q] = (tail_ix[q] + 1) % DEPTH;
          fill_cnt[q]++;
          sched_total++;
        end
      end
      OP_TAKE: begin
        r.status = ST_EMPTY;
        for (int c = 0; c < NCLS; c++) begin
          if (!found && fill_cnt[c] != 0) begin
            r.task_id = id_store[c][head_ix[c]];
            head_ix[c] = (head_ix[c] + 1) % DEPTH;
            fill_cnt[c]--;
            taken_total++;
            r.cls = 3'(c + 1);
            r.status = ST_OK;
            found = 1'b1;
          end
        end
      end
      OP_STEAL: begin
        r.status = ST_EMPTY;
        for (int c = NCLS - 1; c >= 0; c--) begin
          if (!found && fill_cnt[c] != 0) begin
            tail_ix[c] = (tail_ix[c] + DEPTH - 1) % DEPTH;
            r.task_id = id_store[c][tail_ix[c]];
            fill_cnt[c]--;
            stolen_total++;
            r.cls = 3'(c + 1);
            r.status = ST_OK;
            found = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.total = 7'(fill_cnt[0] + fill_cnt[1] + fill_cnt[2] + fill_cnt[3]);
    r.n_sched = sched_total;
    r.n_taken = taken_total;
    r.n_stolen = stolen_total;
    return r;
  endfunction

  task automatic report_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // result side: ready stalls follow the current idling profile
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rcv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual status %0h task %0h",
                 $time, status_o, task_out_o);
        mismatches++;
      end else begin
        want_r = awaited_results[0];
        awaited_results.delete(0);
        n_checked++;
        if (status_o == ST_FULL) n_full++;
        if (status_o == ST_EMPTY) n_empty++;
        report_field("status", 32'(want_r.status), 32'(status_o));
        report_field("task_out", 32'(want_r.task_id), 32'(task_out_o));
        report_field("class_out", 32'(want_r.cls), 32'(class_out_o));
        report_field("queued_total", 32'(want_r.total), 32'(queued_total_o));
        report_field("scheduled_count", want_r.n_sched, scheduled_count_o);
        report_field("taken_count", want_r.n_taken, taken_count_o);
        report_field("stolen_count", want_r.n_stolen, stolen_count_o);
      end
    end
  end

  task automatic send_item(op_e op, logic [15:0] id, logic [2:0] bc);
    int gap;
    gap = 0;
    while ($urandom_range(99) < snd_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    task_id_i <= id;
    burst_class_i <= bc;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  // write the default class, then read it back
  task automatic set_default_class(logic [2:0] v);
    logic [APB_DW-1:0] rd;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_DEFAULT_CLASS, 2'b00};
    pwdata <= {(APB_DW - 4)'($urandom_range(0, (1 << (APB_DW - 4)) - 1)), 1'b0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    dflt_cls = v;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd[2:0] !== v) begin
      $display("%0t: default_class readback mismatch, expected %0h actual %0h",
               $time, v, rd[2:0]);
      cfg_errors++;
    end
  endtask

  initial begin
    logic [2:0] cfg_seq [6];
    int run_left, sched_pct, fav, r;
    op_e op;
    logic [2:0] bc;
    logic [15:0] id;
    int n_sent;
    deque_result_t exp_r;

    // zero and seven are out of range, both fall back to the longest class
    cfg_seq = '{3'd1, 3'd0, 3'd7, 3'd2, 3'd3, 3'd4};
    n_sent = 0;
    run_left = 0;
    sched_pct = 50;
    fav = 1;
    snd_idle_pct = 11;
    rcv_idle_pct = 59;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      for (int k = 0; k < dir_tab[i].reps; k++) begin
        send_item(dir_tab[i].op, dir_tab[i].id + 16'(k), dir_tab[i].cls);
        exp_r = next_deque_result(dir_tab[i].op, dir_tab[i].id + 16'(k), dir_tab[i].cls);
        awaited_results.push_back(dir_tab[i].typed ? dir_tab[i].want : exp_r);
        n_sent++;
      end
    end

    for (int seg = 0; seg < 6; seg++) begin
      // pause the sender until every result is back, then change the setting
      drain_results();
      set_default_class(cfg_seq[seg]);
      case (seg / 2)
        0: begin snd_idle_pct = 11; rcv_idle_pct = 59; end
        1: begin snd_idle_pct = 59; rcv_idle_pct = 11; end
        default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
      endcase
      for (int n = 0; n < 285; n++) begin
        // runs that fill, balance or drain, mostly aimed at one class
        if (run_left == 0) begin
          run_left = $urandom_range(8, 48);
          case ($urandom_range(2))
            0: sched_pct = 85;
            1: sched_pct = 50;
            default: sched_pct = 15;
          endcase
          fav = $urandom_range(1, NCLS);
        end
        run_left--;
        r = $urandom_range(99);
        if (r < 3) op = OP_NONE;
        else if (r < 3 + sched_pct) op = OP_SCHEDULE;
        else op = $urandom_range(1) ? OP_TAKE : OP_STEAL;
        r = $urandom_range(99);
        if (r < 60) bc = 3'(fav);
        else if (r < 85) bc = 3'($urandom_range(1, NCLS));
        else bc = 3'($urandom_range(0, 7));
        id = 16'($urandom_range(0, 65535));
        send_item(op, id, bc);
        awaited_results.push_back(next_deque_result(op, id, bc));
        n_sent++;
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    $display("checked %0d results of %0d transactions, %0d full rejections, %0d empty pops",
             n_checked, n_sent, n_full, n_empty);
    $display("default class swept over in-range and out-of-range values, three stall profiles");
    if (mismatches == 0 && cfg_errors == 0) begin
      $display("burst_class_priority_deque_top test passed");
    end else begin
      $display("burst_class_priority_deque_top test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("burst_class_priority_deque_top test failed");
    $finish;
  end

endmodule
